/* src/ebaf_pkg.sv */
// Shared types and constants for the event background activity filter.
`default_nettype none
package ebaf_pkg;
    localparam int unsigned JUMP_LIMIT_US = 100000;
    localparam int          TIME_BITS     = 48;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_WIDTH,
        REG_HEIGHT,
        REG_WINDOW
    } t_cfg_reg;

    // beat handed from front to back
    typedef struct packed {
        logic [10:0]          x;
        logic [9:0]           y;
        logic [TIME_BITS-1:0] t;
        logic                 first;
        logic                 last;
        logic [TIME_BITS-1:0] low;
    } t_evt;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_OUT
    } t_state;
endpackage
`default_nettype wire

/* src/event_background_activity_filter_top.sv */
// Top level of the event background activity filter.
// Each beat either goes straight to the result or runs the serial neighbor sweep
// (a READ and a CHECK state per neighbor store read) before the result.
// The back stage holds one beat and takes no new one until its result is taken.
// Reset: synchronous, active low; a clearing pass over all MAX_WIDTH*MAX_HEIGHT
// store entries follows reset and each backward jump above 100 ms.
`default_nettype none
module event_background_activity_filter_top
    import ebaf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1280,
    parameter int MAX_HEIGHT = 720
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [10:0] i_event_x,
    input  wire logic [9:0]  i_event_y,
    input  wire logic [TIME_BITS-1:0] i_event_time,
    input  wire logic        i_first_of_packet,
    input  wire logic        i_last_of_packet,
    input  wire logic [TIME_BITS-1:0] i_packet_low_time,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [23:0] i_cfg_data,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [10:0]      o_out_x,
    output logic [9:0]       o_out_y,
    output logic [TIME_BITS-1:0] o_out_time
);
    logic [10:0] r_w;
    logic [9:0]  r_h;
    logic [23:0] r_win;
    t_evt w_in, w_q;
    logic w_qv, w_take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= 11'd1280; r_h <= 10'd720; r_win <= 24'd10000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_WIDTH:  r_w <= i_cfg_data[10:0];
                REG_HEIGHT: r_h <= i_cfg_data[9:0];
                REG_WINDOW: r_win <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign w_in = '{x: i_event_x, y: i_event_y, t: i_event_time,
                    first: i_first_of_packet, last: i_last_of_packet,
                    low: i_packet_low_time};

    ebaf_front u_front (.i_clk, .i_rst_n, .i_valid, .o_stall, .i_evt(w_in),
        .o_valid(w_qv), .i_take(w_take), .o_evt(w_q));

    ebaf_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT))
    u_back (.i_clk, .i_rst_n, .i_valid(w_qv), .o_take(w_take), .i_evt(w_q),
        .i_width(r_w), .i_height(r_h), .i_window(r_win), .o_valid,
        .i_stall, .o_x(o_out_x), .o_y(o_out_y), .o_time(o_out_time));
endmodule
`default_nettype wire

/* src/ebaf_front.sv */
// Front stage: two-entry queue toward the back stage.
`default_nettype none
module ebaf_front
    import ebaf_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_evt i_evt,
    output logic      o_valid,
    input  wire logic i_take,
    output t_evt      o_evt
);
    t_evt       r_q [2];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       w_push, w_pop;

    assign o_stall = (r_cnt == 2'd2);
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_take && (r_cnt != 2'd0);
    assign o_valid = (r_cnt != 2'd0);
    assign o_evt   = r_q[r_rd];

    // queue count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_rd  <= 1'b0;
        end else begin
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
            if (w_pop) r_rd <= ~r_rd;
        end
    end

    // payload write at the tail
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_rd ^ r_cnt[0]] <= i_evt;
    end

    // count stays within the two entries
    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2);
    // head beat holds until taken
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_take |=> o_valid && $stable(o_evt));
endmodule
`default_nettype wire

/* src/ebaf_back.sv */
// Back stage: packet bookkeeping, pixel store sweep over neighbors, output.
`default_nettype none
module ebaf_back
    import ebaf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1280,
    parameter int MAX_HEIGHT = 720
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_take,
    input  wire t_evt        i_evt,
    input  wire logic [10:0] i_width,
    input  wire logic [9:0]  i_height,
    input  wire logic [23:0] i_window,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [10:0]      o_x,
    output logic [9:0]       o_y,
    output logic [TIME_BITS-1:0] o_time
);
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    // pixel store: last time and seen flag; flags cleared by a sweep
    logic [TIME_BITS-1:0] mem_t [DEPTH];
    logic                 mem_s [DEPTH];
    logic [TIME_BITS-1:0] r_rt;
    logic                 r_rs;

    t_state r_st, n_st;
    t_evt   r_e;
    logic [AW-1:0] r_clr;
    logic [3:0]    r_k;
    logic          r_pass, r_swp, r_clrreq;
    logic [TIME_BITS-1:0] r_hm, r_pmax;
    logic          r_hmv, r_clip, r_kept;
    logic [10:0] w_w;
    logic [9:0]  w_h;
    logic [23:0] w_win;
    logic [TIME_BITS-1:0] w_t, w_et, w_low, w_pmax0, w_pmax1;
    logic [1:0]  w_dx, w_dy;
    logic [11:0] w_nx;
    logic [10:0] w_ny;
    logic        w_nok, w_hit;
    logic        w_over, w_jump, w_clip, w_keep, w_kept0, w_kept1;
    logic        w_pt, w_inf, w_swp, w_pthru;
    logic [21:0] w_prod, w_sprod;
    logic [AW-1:0] w_addr, w_self;

    assign w_w   = ({1'b0, i_width} > 12'(MAX_WIDTH)) ? 11'(MAX_WIDTH) : i_width;
    assign w_h   = ({1'b0, i_height} > 11'(MAX_HEIGHT)) ? 10'(MAX_HEIGHT) : i_height;
    assign w_win = (i_window == 24'd0) ? 24'd1 : i_window;
    assign w_t   = r_e.t;
    assign w_et  = i_evt.t;
    assign w_low = i_evt.low;

    // neighbor k (0..8, center skipped) to offsets, coded 0..2 for -1..+1
    always_comb begin
        unique case (r_k)
            4'd0:    begin w_dx = 2'd0; w_dy = 2'd0; end
            4'd1:    begin w_dx = 2'd1; w_dy = 2'd0; end
            4'd2:    begin w_dx = 2'd2; w_dy = 2'd0; end
            4'd3:    begin w_dx = 2'd0; w_dy = 2'd1; end
            4'd5:    begin w_dx = 2'd2; w_dy = 2'd1; end
            4'd6:    begin w_dx = 2'd0; w_dy = 2'd2; end
            4'd7:    begin w_dx = 2'd1; w_dy = 2'd2; end
            4'd8:    begin w_dx = 2'd2; w_dy = 2'd2; end
            default: begin w_dx = 2'd1; w_dy = 2'd1; end
        endcase
    end

    // neighbor position, in-frame test and store addresses
    always_comb begin
        // a step left of column 0 wraps high and fails the bound check
        w_nx    = {1'b0, r_e.x} + 12'(w_dx) - 12'd1;
        w_ny    = {1'b0, r_e.y} + 11'(w_dy) - 11'd1;
        w_nok   = (r_k != 4'd4) && (w_nx < {1'b0, w_w}) && (w_ny < {1'b0, w_h});
        w_prod  = 22'(w_ny[9:0]) * 22'(w_w) + 22'(w_nx[10:0]);
        w_addr  = w_prod[AW-1:0];
        w_sprod = 22'(r_e.y) * 22'(w_w) + 22'(r_e.x);
        w_self  = w_sprod[AW-1:0];
        w_hit   = w_nok && r_rs && (w_t >= r_rt)
               && ((w_t - r_rt) <= TIME_BITS'(w_win));
    end

    // packet check and classification of the front beat
    always_comb begin
        w_over  = i_evt.first && r_hmv && (w_low < r_hm);
        w_jump  = w_over && ((r_hm - w_low) > TIME_BITS'(JUMP_LIMIT_US));
        w_clip  = i_evt.first ? (w_over && !w_jump) : r_clip;
        w_kept0 = i_evt.first ? 1'b0 : r_kept;
        w_pmax0 = i_evt.first ? '0 : r_pmax;
        w_keep  = !(w_clip && (w_et < r_hm));
        w_pmax1 = (w_keep && (!w_kept0 || (w_et > w_pmax0))) ? w_et : w_pmax0;
        w_kept1 = w_kept0 || w_keep;
        w_pt    = (w_w == 11'd0) || (w_h == 10'd0);
        w_inf   = (i_evt.x < w_w) && (i_evt.y < w_h);
        w_swp   = w_keep && !w_pt && w_inf;
        w_pthru = w_keep && w_pt;
    end

    // next state
    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ST_CLEAR: begin
                if (r_clr == LAST_ADDR) begin
                    if (!r_clrreq) n_st = ST_IDLE;
                    else n_st = r_swp ? ST_READ : ST_OUT;
                end
            end
            ST_IDLE: begin
                if (i_valid) n_st = w_jump ? ST_CLEAR : (w_swp ? ST_READ : ST_OUT);
            end
            ST_READ:  n_st = ST_CHECK;
            ST_CHECK: begin
                if (w_hit || r_k == 4'd8) n_st = ST_OUT;
                else n_st = ST_READ;
            end
            ST_OUT:   if (!o_valid || !i_stall) n_st = ST_IDLE;
            default:  n_st = ST_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        o_take = 1'b0;
        unique case (r_st)
            ST_IDLE: o_take = i_valid;
            default: o_take = 1'b0;
        endcase
    end
    assign o_valid = (r_st == ST_OUT) && r_pass;
    assign o_x     = r_e.x;
    assign o_y     = r_e.y;
    assign o_time  = r_e.t;

    // state, bookkeeping and sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_clr <= '0; r_clrreq <= 1'b0; r_hm <= '0;
            r_hmv <= 1'b0; r_clip <= 1'b0; r_kept <= 1'b0; r_pmax <= '0;
            r_k <= '0; r_pass <= 1'b0; r_swp <= 1'b0; r_e <= '0;
        end else begin
            r_st <= n_st;
            unique case (r_st)
                ST_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (n_st != ST_CLEAR) r_clrreq <= 1'b0;
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        r_e <= i_evt; r_k <= 4'd0;
                        r_pass <= w_pthru; r_swp <= w_swp;
                        // a big backward jump sweeps the flags before the sweep
                        if (w_jump) begin
                            r_clr <= '0; r_clrreq <= 1'b1;
                        end
                        // close the packet on its last mark
                        if (i_evt.last) begin
                            if (w_kept1) begin
                                r_hm <= w_pmax1; r_hmv <= 1'b1;
                            end
                            r_clip <= 1'b0; r_kept <= 1'b0; r_pmax <= '0;
                        end else begin
                            r_clip <= w_clip; r_kept <= w_kept1; r_pmax <= w_pmax1;
                        end
                    end
                end
                ST_READ: ;
                ST_CHECK: begin
                    if (n_st == ST_OUT) r_pass <= w_hit;
                    r_k <= (r_k == 4'd3) ? 4'd5 : r_k + 4'd1;
                end
                ST_OUT: ;
                default: ;
            endcase
        end
    end

    // store access: one registered read and at most one write a cycle
    always_ff @(posedge i_clk) begin
        r_rt <= mem_t[w_addr];
        r_rs <= mem_s[w_addr];
        if (r_st == ST_CLEAR) mem_s[r_clr] <= 1'b0;
        else if (r_st == ST_CHECK && n_st == ST_OUT) begin
            mem_t[w_self] <= w_t;
            mem_s[w_self] <= 1'b1;
        end
    end

    // result beat holds while stalled
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable({o_x, o_y, o_time}));
    // beats are taken only when idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n) o_take |-> r_st == ST_IDLE);
    // the sweep never visits the center pixel
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == ST_CHECK |-> r_k != 4'd4 && r_k <= 4'd8);
endmodule
`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for the event background activity filter: directed and random streams.
`timescale 1ns / 100ps
module testbench;
    import ebaf_pkg::*;

    localparam int unsigned MAX_W = 1280;
    localparam int unsigned MAX_H = 720;
    localparam int unsigned STORE_DEPTH = MAX_W * MAX_H;
    localparam int GAP_MAX = 12;
    localparam int DRAIN_CYCLES = 30;

    typedef struct {
        logic [10:0] x;
        logic [9:0]  y;
        logic [47:0] t;
    } t_pix_event;

    // Filter predictor plus queue of events expected to pass
    class filter_scoreboard;
        bit          seen[int unsigned];
        logic [47:0] stamp[int unsigned];
        logic [47:0] high_mark;
        logic [47:0] pkt_max;
        bit          mark_ok;
        bit          clipping;
        bit          pkt_kept;
        int unsigned fw;
        int unsigned fh;
        int unsigned win;
        t_pix_event  passed_q[$];
        int          errors;

        function new();
            fw = 1280;
            fh = 720;
            win = 10000;
            high_mark = '0;
            pkt_max = '0;
            mark_ok = 0;
            clipping = 0;
            pkt_kept = 0;
            errors = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, int unsigned v);
            case (idx)
                REG_WIDTH:  fw = v & 32'h7FF;
                REG_HEIGHT: fh = v & 32'h3FF;
                REG_WINDOW: win = v & 32'hFF_FFFF;
                default: ;
            endcase
        endfunction

        function bit supported(int unsigned nx, int unsigned ny, int unsigned w,
                               logic [47:0] t, int unsigned wn);
            int unsigned idx;
            idx = ny * w + nx;
            if (idx >= STORE_DEPTH || !seen.exists(idx))
                return 0;
            return (t >= stamp[idx]) && ((t - stamp[idx]) <= wn);
        endfunction

        // Apply one accepted beat to the model state
        function void note_event(logic [10:0] x, logic [9:0] y, logic [47:0] t,
                                 bit first, bit last, logic [47:0] low);
            int unsigned w;
            int unsigned h;
            int unsigned wn;
            int unsigned idx;
            int nx;
            int ny;
            bit pass;
            bit sup;
            t_pix_event pe;
            w = (fw > MAX_W) ? MAX_W : fw;
            h = (fh > MAX_H) ? MAX_H : fh;
            wn = (win == 0) ? 1 : win;
            pass = 0;

            // packet check against the previous high mark
            if (first) begin
                pkt_max = '0;
                pkt_kept = 0;
                clipping = 0;
                if (mark_ok && low < high_mark) begin
                    if (high_mark - low > JUMP_LIMIT_US)
                        seen.delete();
                    else
                        clipping = 1;
                end
            end

            if (!(clipping && t < high_mark)) begin
                if (!pkt_kept || t > pkt_max)
                    pkt_max = t;
                pkt_kept = 1;
                if (w == 0 || h == 0) begin
                    pass = 1;
                end else if (x < w && y < h) begin
                    sup = 0;
                    for (int dy = -1; dy <= 1; dy++) begin
                        for (int dx = -1; dx <= 1; dx++) begin
                            ny = int'(y) + dy;
                            nx = int'(x) + dx;
                            if (ny < 0 || ny >= int'(h) || nx < 0 || nx >= int'(w)
                                || (dx == 0 && dy == 0))
                                continue;
                            if (supported(nx, ny, w, t, wn))
                                sup = 1;
                        end
                    end
                    idx = y * w + x;
                    if (idx < STORE_DEPTH) begin
                        stamp[idx] = t;
                        seen[idx] = 1;
                    end
                    pass = sup;
                end
            end

            // close the packet
            if (last) begin
                if (pkt_kept) begin
                    high_mark = pkt_max;
                    mark_ok = 1;
                end
                clipping = 0;
                pkt_kept = 0;
                pkt_max = '0;
            end

            if (pass) begin
                pe = '{x, y, t};
                passed_q = {passed_q, pe};
            end
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $time, msg);
            errors++;
        endtask

        task check_result(logic [10:0] x, logic [9:0] y, logic [47:0] t);
            t_pix_event exp_ev;
            if (passed_q.size() == 0) begin
                report($sformatf("unexpected event x=%0d y=%0d t=%0d", x, y, t));
            end else begin
                exp_ev = passed_q.pop_front();
                if (x !== exp_ev.x)
                    report($sformatf("x got %0d want %0d", x, exp_ev.x));
                if (y !== exp_ev.y)
                    report($sformatf("y got %0d want %0d", y, exp_ev.y));
                if (t !== exp_ev.t)
                    report($sformatf("time got %0d want %0d", t, exp_ev.t));
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [10:0] i_event_x;
    logic [9:0]  i_event_y;
    logic [47:0] i_event_time;
    logic        i_first_of_packet;
    logic        i_last_of_packet;
    logic [47:0] i_packet_low_time;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [23:0] i_cfg_data;
    logic        o_valid;
    logic        i_stall;
    logic [10:0] o_out_x;
    logic [9:0]  o_out_y;
    logic [47:0] o_out_time;

    filter_scoreboard sb = new();
    bit tx_gaps;
    bit rx_gaps;

    event_background_activity_filter_top dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_event_x(i_event_x),
        .i_event_y(i_event_y),
        .i_event_time(i_event_time),
        .i_first_of_packet(i_first_of_packet),
        .i_last_of_packet(i_last_of_packet),
        .i_packet_low_time(i_packet_low_time),
        .i_cfg_we(i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out_x(o_out_x),
        .o_out_y(o_out_y),
        .o_out_time(o_out_time)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Send one event beat, optionally after an idle gap
    task automatic send_event(logic [10:0] x, logic [9:0] y, logic [47:0] t,
                              bit first, bit last, logic [47:0] low);
        int gap;
        gap = tx_gaps ? $urandom_range(0, GAP_MAX) : 0;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_event_x <= x;
        i_event_y <= y;
        i_event_time <= t;
        i_first_of_packet <= first;
        i_last_of_packet <= last;
        i_packet_low_time <= low;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_event(x, y, t, first, last, low);
    endtask

    // Wait until the block holds no beat, then let the result side finish
    task automatic settle();
        i_valid <= 1'b0;
        repeat (2) @(posedge i_clk);
        while (dut.w_qv || dut.u_back.r_st != ST_IDLE) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_frame(int unsigned w, int unsigned h, int unsigned win);
        i_cfg_we <= 1'b1;
        i_cfg_index <= REG_WIDTH;
        i_cfg_data <= 24'(w);
        @(posedge i_clk);
        i_cfg_index <= REG_HEIGHT;
        i_cfg_data <= 24'(h);
        @(posedge i_clk);
        i_cfg_index <= REG_WINDOW;
        i_cfg_data <= 24'(win);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.write_reg(REG_WIDTH, w);
        sb.write_reg(REG_HEIGHT, h);
        sb.write_reg(REG_WINDOW, win);
    endtask

    // Random packets clustered around a spot so neighbors fire
    task automatic run_phase(int n, int unsigned w, int unsigned h, int unsigned win,
                             logic [47:0] start);
        int sent;
        int len;
        int kind;
        int unsigned xs;
        int unsigned ys;
        int unsigned cx;
        int unsigned cy;
        int unsigned step;
        logic [47:0] now;
        logic [47:0] low;
        logic [47:0] t;
        logic [10:0] x;
        logic [9:0]  y;
        bit f;
        bit l;
        sent = 0;
        now = start;
        step = ((win == 0) ? 1 : win) * 2;
        xs = (w == 0) ? 64 : ((w > MAX_W) ? MAX_W : w);
        ys = (h == 0) ? 64 : ((h > MAX_H) ? MAX_H : h);
        while (sent < n) begin
            len = $urandom_range(1, 8);
            kind = $urandom_range(0, 11);
            cx = $urandom_range(0, xs);
            cy = $urandom_range(0, ys);
            low = now;
            // overlapping packet: low a little under the high mark
            if (kind == 0 && sb.mark_ok && sb.high_mark > 60000)
                low = sb.high_mark - $urandom_range(1, 50000);
            for (int i = 0; i < len; i++) begin
                // kind 1 drops the first mark, kind 2 the last mark
                f = (i == 0) && (kind != 1);
                l = (i == len - 1) && (kind != 2);
                now += $urandom_range(0, step);
                t = now;
                if (kind == 0 && $urandom_range(0, 1)) begin
                    t = low + $urandom_range(0, 60000);
                    if (t > now)
                        now = t;
                end
                if ($urandom_range(0, 11) == 0) begin
                    x = 11'($urandom);
                    y = 10'($urandom);
                end else begin
                    x = 11'(cx + $urandom_range(0, 2));
                    y = 10'(cy + $urandom_range(0, 2));
                end
                send_event(x, y, t, f, l, low);
                sent++;
            end
        end
        settle();
    endtask

    // Result side: random stall, then take one beat
    initial begin
        @(posedge i_clk);
        forever begin
            int n;
            n = rx_gaps ? $urandom_range(0, GAP_MAX) : 0;
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            sb.check_result(o_out_x, o_out_y, o_out_time);
        end
    end

    initial begin
        #200_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Main sequence
    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_stall <= 1'b1;
        i_event_x <= '0;
        i_event_y <= '0;
        i_event_time <= '0;
        i_first_of_packet <= 1'b0;
        i_last_of_packet <= 1'b0;
        i_packet_low_time <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_WIDTH;
        i_cfg_data <= '0;
        tx_gaps = 1;
        rx_gaps = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        set_frame(1280, 720, 10000);

        // corners, neighbor support, out of frame, stale and future neighbors
        send_event(0, 0, 1000, 1, 0, 1000);
        send_event(1, 0, 1005, 0, 0, 0);
        send_event(1279, 719, 1010, 0, 0, 0);
        send_event(1278, 719, 2000, 0, 0, 0);
        send_event(2047, 1023, 3000, 0, 0, 0);
        send_event(1280, 5, 3001, 0, 0, 0);
        send_event(5, 720, 3002, 0, 0, 0);
        send_event(2, 0, 20000, 0, 0, 0);
        send_event(2, 1, 19000, 0, 1, 0);
        // small overlap clips early events of the next packet
        send_event(3, 1, 16000, 1, 0, 15000);
        send_event(3, 1, 25000, 0, 1, 0);
        // marks without partners, then a big backward jump clears the store
        send_event(10, 10, 300000, 1, 1, 300000);
        send_event(11, 11, 300001, 0, 0, 0);
        send_event(12, 12, 300002, 0, 1, 0);
        send_event(11, 10, 300005, 1, 1, 100);
        settle();

        // pass-through with zero width, extreme field values
        set_frame(0, 720, 10000);
        send_event(2047, 1023, 48'hFFFF_FFFF_FFFF, 0, 0, 48'hFFFF_FFFF_FFFF);
        send_event(5, 5, 0, 1, 1, 48'hFFFF_FFFF_FFFF);
        settle();

        set_frame(8, 6, 40);
        run_phase(190, 8, 6, 40, 48'd1000);
        tx_gaps = 0;
        rx_gaps = 0;
        set_frame(16, 4, 1);
        run_phase(190, 16, 4, 1, 48'd5_000_000);
        tx_gaps = 1;
        rx_gaps = 1;
        set_frame(2047, 1023, 24'hFF_FFFF);
        run_phase(190, 2047, 1023, 24'hFF_FFFF, 48'h0000_8000_0000);
        rx_gaps = 0;
        set_frame(3, 3, 100);
        run_phase(190, 3, 3, 100, 48'h0100_0000_0000);
        rx_gaps = 1;
        set_frame(40, 0, 500);
        run_phase(190, 40, 0, 500, 48'hF000_0000_0000);

        if (sb.errors == 0 && sb.passed_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
